// ----- design/lfp_pkg.sv -----
// ----------------------------------------------------------------------------
// lfp_pkg: shared types and constants for the line-follow PID block
// Register indexes, reset values, fixed-point reciprocals and stage structs.
// ----------------------------------------------------------------------------
package lfp_pkg;

  // Field widths
  localparam int unsigned RefW   = 10;
  localparam int unsigned PosW   = 12;
  localparam int unsigned MsW    = 8;
  localparam int unsigned TimerW = 16;
  localparam int unsigned SpeedW = 8;
  localparam int unsigned CountW = 4;
  localparam int unsigned ErrW   = 13;
  localparam int unsigned DerW   = 14;
  localparam int unsigned IntW   = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 24;

  // Control constants
  localparam logic [PosW-1:0]   CenterPos = 12'd2000;
  localparam logic [CountW-1:0] CountMax  = 4'd15;
  localparam logic [CountW-1:0] LevelRst  = 4'd4;

  // Truncating /20 as (x>>2)*820>>12 for x below 2^10
  localparam logic [9:0]  PRecip  = 10'd820;
  localparam int unsigned PShift  = 12;
  // Truncating /10000 as (x>>4)*219902326>>37 for x below 2^28
  localparam logic [27:0] IRecip  = 28'd219902326;
  localparam int unsigned IShift  = 37;

  // Register reset values
  localparam logic [RefW-1:0]   SignThrRst   = 10'd200;
  localparam logic [RefW-1:0]   MidThrRst    = 10'd100;
  localparam logic [TimerW-1:0] GapTimeoutRst = 16'd500;
  localparam logic [SpeedW-1:0] SpeedOneRst  = 8'd155;
  localparam logic [SpeedW-1:0] SpeedTwoRst  = 8'd160;
  localparam logic [SpeedW-1:0] SpeedThreeRst = 8'd180;
  localparam logic [SpeedW-1:0] SpeedFourRst = 8'd190;

  // Register indexes on the write port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SIGN_THR    = 3'd0,
    CFG_MID_THR     = 3'd1,
    CFG_GAP_TIMEOUT = 3'd2,
    CFG_SPEED_ONE   = 3'd3,
    CFG_SPEED_TWO   = 3'd4,
    CFG_SPEED_THREE = 3'd5,
    CFG_SPEED_FOUR  = 3'd6
  } lfp_cfg_idx_e;

  // Work handed from the state stage to the drive arithmetic
  typedef struct packed {
    logic                    tone;
    logic [2:0]              shown;
    logic [SpeedW-1:0]       speed;
    logic signed [ErrW-1:0]  err;
    logic signed [DerW-1:0]  deriv;
    logic signed [IntW-1:0]  integ;
  } lfp_work_t;

  // Finished result
  typedef struct packed {
    logic [SpeedW-1:0] left;
    logic [SpeedW-1:0] right;
    logic              tone;
    logic [2:0]        shown;
  } lfp_res_t;

endpackage

// ----- design/lfp_drive.sv -----
// ----------------------------------------------------------------------------
// lfp_drive: PID term and motor drive arithmetic
// Two register stages: constant divisions by reciprocal multiply, then sum,
// clamp to the base speed and split into left and right drives.
// ----------------------------------------------------------------------------
module lfp_drive
  import lfp_pkg::*;
(
  input  logic      clk_i,
  input  logic      en_i,
  input  lfp_work_t work_i,
  output lfp_res_t  res_o
);

  // Stage C registers
  logic signed [7:0]  p_d, p_q;
  logic signed [14:0] dh_d, dh_q;
  logic [55:0]        iprod_d, iprod_q;
  logic               ineg_q;
  logic [SpeedW-1:0]  speed_q;
  logic               tone_q;
  logic [2:0]         shown_q;

  // Proportional, derivative and integral magnitude products
  logic [11:0]        err_mag;
  logic [19:0]        p_prod;
  logic [6:0]         p_quo;
  logic signed [15:0] d_ext;
  logic signed [15:0] d3;
  logic signed [15:0] d_half;
  logic [IntW-1:0]    i_mag;

  always_comb begin
    err_mag = work_i.err[ErrW-1] ? 12'(-work_i.err) : 12'(work_i.err);
    p_prod  = 20'(err_mag[11:2]) * 20'(PRecip);
    p_quo   = p_prod[18:PShift];
    p_d     = work_i.err[ErrW-1] ? -signed'({1'b0, p_quo}) : signed'({1'b0, p_quo});

    // deriv*3/2, truncated toward zero
    d_ext  = 16'(work_i.deriv);
    d3     = d_ext + (d_ext <<< 1);
    d_half = (d3 + signed'({15'b0, d3[15]})) >>> 1;
    dh_d   = 15'(d_half);

    i_mag   = work_i.integ[IntW-1] ? 32'(-work_i.integ) : 32'(work_i.integ);
    iprod_d = 56'(i_mag[31:4]) * 56'(IRecip);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q     <= p_d;
      dh_q    <= dh_d;
      iprod_q <= iprod_d;
      ineg_q  <= work_i.integ[IntW-1];
      speed_q <= work_i.speed;
      tone_q  <= work_i.tone;
      shown_q <= work_i.shown;
    end
  end

  // Sum, clamp and split
  logic [18:0]        i_quo;
  logic signed [19:0] i_val;
  logic signed [20:0] drive;
  logic signed [20:0] spd;
  logic signed [20:0] clamped;
  lfp_res_t           res_d, res_q;

  always_comb begin
    i_quo = iprod_q[55:IShift];
    i_val = ineg_q ? -signed'({1'b0, i_quo}) : signed'({1'b0, i_quo});
    drive = 21'(p_q) + 21'(i_val) + 21'(dh_q);
    spd   = signed'(21'(speed_q));
    if (drive > spd) begin
      clamped = spd;
    end else if (drive < -spd) begin
      clamped = -spd;
    end else begin
      clamped = drive;
    end
    if (clamped < 0) begin
      res_d.left  = 8'(spd + clamped);
      res_d.right = speed_q;
    end else begin
      res_d.left  = speed_q;
      res_d.right = 8'(spd - clamped);
    end
    res_d.tone  = tone_q;
    res_d.shown = shown_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ----- design/line_follow_pid_with_sign_speed.sv -----
// ----------------------------------------------------------------------------
// line_follow_pid_with_sign_speed: line follower PID with sign speed select
// Sign detection, sign count and gap timer, PID error state, and the drive
// pipeline producing left and right motor values per sensor sample.
// ----------------------------------------------------------------------------
// Path: an accepted request passes the input register, state stage, divide stage
// and output register. Throughput: one request per cycle; the whole four-stage
// pipe holds on a stall.
// Reset: config registers take their defaults; sign count 0, level 4, timer,
// previous error and integral 0; all stage valid bits cleared.
module line_follow_pid_with_sign_speed
  import lfp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // reflect_0..reflect_4, line_position, elapsed_ms (low bit upwards)
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  // left_drive, right_drive, tone_on, speed_level (low bit upwards)
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i
);

  // Configuration registers
  logic [RefW-1:0]   sign_thr_q, mid_thr_q;
  logic [TimerW-1:0] gap_timeout_q;
  logic [SpeedW-1:0] spd_one_q, spd_two_q, spd_three_q, spd_four_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sign_thr_q    <= SignThrRst;
      mid_thr_q     <= MidThrRst;
      gap_timeout_q <= GapTimeoutRst;
      spd_one_q     <= SpeedOneRst;
      spd_two_q     <= SpeedTwoRst;
      spd_three_q   <= SpeedThreeRst;
      spd_four_q    <= SpeedFourRst;
    end else if (cfg_we_i) begin
      unique case (lfp_cfg_idx_e'(cfg_idx_i))
        CFG_SIGN_THR:    sign_thr_q    <= cfg_data_i[RefW-1:0];
        CFG_MID_THR:     mid_thr_q     <= cfg_data_i[RefW-1:0];
        CFG_GAP_TIMEOUT: gap_timeout_q <= cfg_data_i[TimerW-1:0];
        CFG_SPEED_ONE:   spd_one_q     <= cfg_data_i[SpeedW-1:0];
        CFG_SPEED_TWO:   spd_two_q     <= cfg_data_i[SpeedW-1:0];
        CFG_SPEED_THREE: spd_three_q   <= cfg_data_i[SpeedW-1:0];
        CFG_SPEED_FOUR:  spd_four_q    <= cfg_data_i[SpeedW-1:0];
        default: ;
      endcase
    end
  end

  // Pipe advance: every stage moves together when the output is free
  logic adv;
  logic a_vld_q, b_vld_q, c_vld_q, o_vld_q;

  assign adv           = !o_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= s_axis_tvalid;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      o_vld_q <= c_vld_q;
    end
  end

  // Input register
  logic [InDataW-1:0] in_q;

  always_ff @(posedge clk_i) begin
    if (adv && s_axis_tvalid) begin
      in_q <= s_axis_tdata;
    end
  end

  logic [RefW-1:0] r0, r1, r2, r3, r4;
  logic [PosW-1:0] pos;
  logic [MsW-1:0]  elapsed;

  assign r0      = in_q[9:0];
  assign r1      = in_q[19:10];
  assign r2      = in_q[29:20];
  assign r3      = in_q[39:30];
  assign r4      = in_q[49:40];
  assign pos     = in_q[61:50];
  assign elapsed = in_q[69:62];

  // Sign tracking and PID state
  logic [CountW-1:0]      count_q, count_d;
  logic [CountW-1:0]      level_q, level_d;
  logic                   on_sign_q, on_sign_d;
  logic [TimerW-1:0]      timer_q, timer_d;
  logic signed [ErrW-1:0] prev_err_q;
  logic signed [IntW-1:0] integ_q, integ_d;

  logic                   sign_seen;
  logic [TimerW:0]        tsum;
  logic [TimerW-1:0]      tsat;
  logic signed [ErrW-1:0] err;
  logic signed [IntW:0]   isum;
  lfp_work_t              work_d, work_q;

  always_comb begin
    tsum = {1'b0, timer_q} + (TimerW+1)'(elapsed);
    tsat = tsum[TimerW] ? {TimerW{1'b1}} : tsum[TimerW-1:0];
    sign_seen = (r0 > sign_thr_q) && (r1 > sign_thr_q) && (r2 > sign_thr_q) &&
                (r3 > mid_thr_q) && (r4 > sign_thr_q);

    count_d   = count_q;
    level_d   = level_q;
    on_sign_d = on_sign_q;
    timer_d   = tsat;
    priority if (sign_seen) begin
      on_sign_d = 1'b1;
    end else if (on_sign_q) begin
      on_sign_d = 1'b0;
      count_d   = (count_q < CountMax) ? count_q + 4'd1 : count_q;
      level_d   = count_d;
      timer_d   = '0;
    end else if (tsat > gap_timeout_q) begin
      count_d = '0;
      timer_d = '0;
    end

    // Base speed from the new level
    work_d.tone = sign_seen;
    if (level_d <= 4'd1) begin
      work_d.speed = spd_one_q;
      work_d.shown = 3'd1;
    end else if (level_d == 4'd2) begin
      work_d.speed = spd_two_q;
      work_d.shown = 3'd2;
    end else if (level_d == 4'd3) begin
      work_d.speed = spd_three_q;
      work_d.shown = 3'd3;
    end else begin
      work_d.speed = spd_four_q;
      work_d.shown = 3'd4;
    end

    // Error, derivative, saturating integral
    err  = signed'({1'b0, pos}) - signed'({1'b0, CenterPos});
    isum = 33'(integ_q) + 33'(err);
    if (isum[IntW] != isum[IntW-1]) begin
      integ_d = isum[IntW] ? {1'b1, {(IntW-1){1'b0}}} : {1'b0, {(IntW-1){1'b1}}};
    end else begin
      integ_d = isum[IntW-1:0];
    end
    work_d.err   = err;
    work_d.deriv = 14'(err) - 14'(prev_err_q);
    work_d.integ = integ_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      level_q    <= LevelRst;
      on_sign_q  <= 1'b0;
      timer_q    <= '0;
      prev_err_q <= '0;
      integ_q    <= '0;
    end else if (adv && a_vld_q) begin
      count_q    <= count_d;
      level_q    <= level_d;
      on_sign_q  <= on_sign_d;
      timer_q    <= timer_d;
      prev_err_q <= err;
      integ_q    <= integ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      work_q <= work_d;
    end
  end

  // Divide stage and output register
  lfp_res_t res;

  lfp_drive u_drive (
    .clk_i  (clk_i),
    .en_i   (adv),
    .work_i (work_q),
    .res_o  (res)
  );

  assign m_axis_tvalid = o_vld_q;
  assign m_axis_tdata  = {4'b0, res.shown, res.tone, res.right, res.left};

endmodule

// ----- design/lfp_checker.sv -----
// ----------------------------------------------------------------------------
// lfp_sva: port-level checks for the line-follow PID block
// Watches reset emptiness, stall behaviour and the displayed speed level.
// ----------------------------------------------------------------------------
module lfp_sva
  import lfp_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // Pipe is empty straight after reset
  a_empty_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result shown straight after reset");

  // Input side never blocks while the output is free
  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input stalled while output free");

  // Stalled result holds
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // Displayed level is 1 to 4 and padding is zero
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[19:17] != 3'd0) && (m_axis_tdata[19:17] <= 3'd4)
                       && (m_axis_tdata[23:20] == 4'd0)))
    else $error("speed level out of range");

endmodule

bind line_follow_pid_with_sign_speed lfp_sva u_lfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- sim/lfp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfp_checker: scoreboard for the line-follow PID block
// Watches the sample and drive streams and the register write port, keeps its
// own copy of the controller state, predicts one drive result per request and
// compares each returned result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lfp_checker
  import lfp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // sample stream: reflect_0..reflect_4, line_position, elapsed_ms
  input  logic                req_valid_i,
  input  logic                req_ready_i,
  input  logic [InDataW-1:0]  req_data_i,
  // drive stream: left_drive, right_drive, tone_on, speed_level
  input  logic                res_valid_i,
  input  logic                res_ready_i,
  input  logic [OutDataW-1:0] res_data_i,
  // register writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  output int                  fail_count_o,
  output int                  drive_pending_o
);

  localparam longint PropDiv  = 20;
  localparam longint IntegDiv = 10000;
  localparam longint DerivMul = 3;
  localparam longint DerivDiv = 2;
  localparam longint IntegMax = 64'sd2147483647;
  localparam longint IntegMin = -64'sd2147483648;
  localparam longint TimerMax = 65535;

  // Register copies
  logic [RefW-1:0]   thr_sign;
  logic [RefW-1:0]   thr_mid;
  logic [TimerW-1:0] timeout_ms;
  logic [SpeedW-1:0] base_speed [4];

  // Controller state
  logic [CountW-1:0] signs_seen;
  logic [CountW-1:0] lvl;
  logic              crossing;
  logic [TimerW-1:0] gap_ms;
  int                last_err;
  int                err_sum;

  lfp_res_t drive_q [$];
  lfp_res_t seen_res;
  lfp_res_t want_res;

  task automatic report_miss(input string what, input int got, input int want);
    $display("%0t: %s got %0d want %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  // One sensor sample in, one drive result out; updates the state copy
  function automatic lfp_res_t steer_sample(input logic [InDataW-1:0] d);
    lfp_res_t        r;
    logic [RefW-1:0] refl [5];
    longint          pos, ms, tsum, spd, e, de, acc, drv;
    logic            seen;
    for (int k = 0; k < 5; k++) refl[k] = d[k*RefW +: RefW];
    pos = d[5*RefW +: PosW];
    ms  = d[5*RefW+PosW +: MsW];

    tsum = longint'(gap_ms) + ms;
    if (tsum > TimerMax) tsum = TimerMax;
    gap_ms = TimerW'(tsum);

    seen = refl[0] > thr_sign && refl[1] > thr_sign && refl[2] > thr_sign &&
           refl[3] > thr_mid && refl[4] > thr_sign;

    // leaving a sign counts it; a long quiet stretch clears the count
    if (seen) begin
      crossing = 1'b1;
    end else if (crossing) begin
      crossing = 1'b0;
      if (signs_seen != CountMax) signs_seen = signs_seen + 1'b1;
      lvl    = signs_seen;
      gap_ms = '0;
    end else if (gap_ms > timeout_ms) begin
      signs_seen = '0;
      gap_ms     = '0;
    end

    if (lvl <= 4'd1) begin
      spd = base_speed[0];
      r.shown = 3'd1;
    end else if (lvl == 4'd2) begin
      spd = base_speed[1];
      r.shown = 3'd2;
    end else if (lvl == 4'd3) begin
      spd = base_speed[2];
      r.shown = 3'd3;
    end else begin
      spd = base_speed[3];
      r.shown = 3'd4;
    end

    // PID, integral saturating and updated before use
    e   = pos - longint'(CenterPos);
    de  = e - longint'(last_err);
    acc = longint'(err_sum) + e;
    if (acc > IntegMax) acc = IntegMax;
    if (acc < IntegMin) acc = IntegMin;
    err_sum  = int'(acc);
    last_err = int'(e);

    drv = e / PropDiv + acc / IntegDiv + (de * DerivMul) / DerivDiv;
    if (drv > spd) drv = spd;
    if (drv < -spd) drv = -spd;

    if (drv < 0) begin
      r.left  = SpeedW'(spd + drv);
      r.right = SpeedW'(spd);
    end else begin
      r.left  = SpeedW'(spd);
      r.right = SpeedW'(spd - drv);
    end
    r.tone = seen;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_sign      = SignThrRst;
      thr_mid       = MidThrRst;
      timeout_ms    = GapTimeoutRst;
      base_speed[0] = SpeedOneRst;
      base_speed[1] = SpeedTwoRst;
      base_speed[2] = SpeedThreeRst;
      base_speed[3] = SpeedFourRst;
      signs_seen    = '0;
      lvl           = LevelRst;
      crossing      = 1'b0;
      gap_ms        = '0;
      last_err      = 0;
      err_sum       = 0;
      drive_q.delete();
      fail_count_o  = 0;
      drive_pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (lfp_cfg_idx_e'(cfg_idx_i))
          CFG_SIGN_THR:    thr_sign      = cfg_data_i[RefW-1:0];
          CFG_MID_THR:     thr_mid       = cfg_data_i[RefW-1:0];
          CFG_GAP_TIMEOUT: timeout_ms    = cfg_data_i[TimerW-1:0];
          CFG_SPEED_ONE:   base_speed[0] = cfg_data_i[SpeedW-1:0];
          CFG_SPEED_TWO:   base_speed[1] = cfg_data_i[SpeedW-1:0];
          CFG_SPEED_THREE: base_speed[2] = cfg_data_i[SpeedW-1:0];
          CFG_SPEED_FOUR:  base_speed[3] = cfg_data_i[SpeedW-1:0];
          default: ;
        endcase
      end

      // returned result against the oldest prediction
      if (res_valid_i && res_ready_i) begin
        seen_res.left  = res_data_i[0 +: SpeedW];
        seen_res.right = res_data_i[SpeedW +: SpeedW];
        seen_res.tone  = res_data_i[2*SpeedW];
        seen_res.shown = res_data_i[2*SpeedW+1 +: 3];
        if (drive_q.size() == 0) begin
          report_miss("result with nothing pending, left_drive", seen_res.left, 0);
        end else begin
          want_res = drive_q.pop_front();
          if (seen_res.left != want_res.left)
            report_miss("left_drive", seen_res.left, want_res.left);
          if (seen_res.right != want_res.right)
            report_miss("right_drive", seen_res.right, want_res.right);
          if (seen_res.tone != want_res.tone)
            report_miss("tone_on", seen_res.tone, want_res.tone);
          if (seen_res.shown != want_res.shown)
            report_miss("speed_level", seen_res.shown, want_res.shown);
        end
      end

      if (req_valid_i && req_ready_i) drive_q.push_back(steer_sample(req_data_i));
      drive_pending_o <= drive_q.size();
    end
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for line_follow_pid_with_sign_speed
// Drives sensor samples (a directed opening, then sign crossings, quiet gaps
// and noise under several register settings and idling patterns) and hands
// checking to lfp_checker; gives the final verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import lfp_pkg::*;

  localparam int QuietLimit  = 2000;
  localparam int DrainCycles = 10;
  localparam int HoldCycles  = 60;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgW-1:0]     cfg_data = '0;

  int  fail_count;
  int  drive_pending;
  int  quiet_cycles = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_tgl = 1'b0;
  bit  hold_seen = 1'b0;
  int  hold_left = 0;
  int  cur_thr_sign = SignThrRst;
  int  cur_thr_mid = MidThrRst;
  int  burst_left = 0;
  bit  long_gaps = 1'b0;

  always #5 clk = ~clk;

  line_follow_pid_with_sign_speed dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  lfp_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .req_valid_i     (s_axis_tvalid),
    .req_ready_i     (s_axis_tready),
    .req_data_i      (s_axis_tdata),
    .res_valid_i     (m_axis_tvalid),
    .res_ready_i     (m_axis_tready),
    .res_data_i      (m_axis_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_count),
    .drive_pending_o (drive_pending)
  );

  // Receiver: random stalls, plus a long counted hold-off on request
  always @(posedge clk) begin
    if (hold_tgl != hold_seen) begin
      hold_seen     <= hold_tgl;
      hold_left     <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles with no transfer on either stream
  always @(posedge clk) begin
    if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("line_follow_pid_with_sign_speed: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [InDataW-1:0] pack_sample(input int r0, r1, r2, r3, r4,
                                                     input int pos, ms);
    logic [InDataW-1:0] d;
    d = '0;
    d[0*RefW +: RefW]      = r0[RefW-1:0];
    d[1*RefW +: RefW]      = r1[RefW-1:0];
    d[2*RefW +: RefW]      = r2[RefW-1:0];
    d[3*RefW +: RefW]      = r3[RefW-1:0];
    d[4*RefW +: RefW]      = r4[RefW-1:0];
    d[5*RefW +: PosW]      = pos[PosW-1:0];
    d[5*RefW+PosW +: MsW]  = ms[MsW-1:0];
    return d;
  endfunction

  // Offer one request, with random idle cycles first; returns at its accepting edge
  task automatic push_sample(input logic [InDataW-1:0] d);
    bit ok;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do begin
      @(negedge clk);
      ok = s_axis_tready;
      @(posedge clk);
    end while (!ok);
  endtask

  // Well-formed track: sign bursts with clear samples between, plus some noise
  task automatic make_track_sample(output logic [InDataW-1:0] d);
    int r [5];
    int pos, ms, pick, j, lim;
    pick = $urandom_range(99);
    if (pick < 12) begin
      for (j = 0; j < 5; j++) r[j] = $urandom_range(1023);
      pos = $urandom_range(4095);
      ms  = $urandom_range(255);
    end else begin
      if (burst_left == 0 && !long_gaps && $urandom_range(99) < 20)
        burst_left = $urandom_range(3, 1);
      if (burst_left != 0) begin
        for (j = 0; j < 5; j++)
          r[j] = $urandom_range(1023, ((j == 3) ? cur_thr_mid : cur_thr_sign) + 1);
        burst_left--;
      end else begin
        for (j = 0; j < 5; j++) r[j] = $urandom_range(1023);
        j = $urandom_range(4);
        lim = (j == 3) ? cur_thr_mid : cur_thr_sign;
        r[j] = ($urandom_range(3) == 0) ? lim : $urandom_range(lim);
      end
      pos = ($urandom_range(9) == 0) ? $urandom_range(4095) : 1600 + $urandom_range(800);
      pick = $urandom_range(99);
      if (long_gaps)     ms = $urandom_range(255, 224);
      else if (pick < 85) ms = $urandom_range(15);
      else if (pick < 95) ms = $urandom_range(255, 16);
      else               ms = 255;
    end
    d = pack_sample(r[0], r[1], r[2], r[3], r[4], pos, ms);
  endtask

  task automatic write_reg(input lfp_cfg_idx_e idx, input int value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value[CfgW-1:0];
    @(posedge clk);
  endtask

  task automatic load_setup(input int thr, mid, tmo, sp1, sp2, sp3, sp4);
    write_reg(CFG_SIGN_THR, thr);
    write_reg(CFG_MID_THR, mid);
    write_reg(CFG_GAP_TIMEOUT, tmo);
    write_reg(CFG_SPEED_ONE, sp1);
    write_reg(CFG_SPEED_TWO, sp2);
    write_reg(CFG_SPEED_THREE, sp3);
    write_reg(CFG_SPEED_FOUR, sp4);
    cfg_we       <= 1'b0;
    cur_thr_sign = thr;
    cur_thr_mid  = mid;
  endtask

  // Let every outstanding request come back, then wait out DrainCycles as well
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (drive_pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic run_phase(input int count, send_pct, stall_pct, input bit gaps, squeeze);
    logic [InDataW-1:0] d;
    send_idle_pct  = send_pct;
    recv_stall_pct <= stall_pct;
    long_gaps      = gaps;
    burst_left     = 0;
    for (int n = 0; n < count; n++) begin
      make_track_sample(d);
      if (squeeze && n == 40) hold_tgl <= ~hold_tgl;
      push_sample(d);
    end
    drain_results();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening under reset settings
    push_sample(pack_sample(0, 0, 0, 0, 0, 0, 0));
    push_sample(pack_sample(1023, 1023, 1023, 1023, 1023, 4095, 255));   // sign
    push_sample(pack_sample(0, 0, 0, 0, 0, 2000, 0));                    // leave: level 1
    push_sample(pack_sample(201, 201, 201, 101, 201, 2000, 1));          // just above
    push_sample(pack_sample(200, 200, 200, 100, 200, 2000, 1));          // at thresholds
    push_sample(pack_sample(1023, 1023, 1023, 100, 1023, 1999, 2));      // middle right low
    push_sample(pack_sample(1023, 1023, 1023, 1023, 1023, 2001, 3));
    push_sample(pack_sample(1000, 1000, 1000, 1000, 1000, 2000, 0));     // sign held
    push_sample(pack_sample(512, 341, 682, 0, 1023, 3000, 4));           // level 3
    push_sample(pack_sample(1023, 1023, 1023, 1023, 1023, 1000, 5));
    push_sample(pack_sample(0, 1023, 1023, 1023, 1023, 2000, 0));        // level 4
    push_sample(pack_sample(0, 0, 0, 0, 0, 4000, 255));
    push_sample(pack_sample(0, 0, 0, 0, 0, 4000, 255));                  // timeout
    push_sample(pack_sample(1023, 1023, 1023, 1023, 1023, 0, 0));
    push_sample(pack_sample(1023, 1023, 1023, 1023, 0, 0, 0));           // back to level 1
    push_sample(pack_sample(1, 2, 4, 8, 16, 4095, 0));
    push_sample(pack_sample(32, 64, 128, 256, 512, 0, 0));
    push_sample(pack_sample(0, 0, 0, 0, 0, 2000, 0));
    push_sample(pack_sample(0, 0, 0, 0, 0, 1, 128));
    push_sample(pack_sample(0, 0, 0, 0, 0, 3999, 127));
    push_sample(pack_sample(1023, 0, 1023, 0, 1023, 2048, 64));
    drain_results();

    // Random register settings, no idling, with a long receiver hold-off
    load_setup($urandom_range(1000), $urandom_range(1000), $urandom_range(2000),
               $urandom_range(255), $urandom_range(255), $urandom_range(255),
               $urandom_range(255));
    run_phase(120, 0, 0, 1'b0, 1'b1);

    // Reset thresholds, no timeout in practice so the count can saturate
    load_setup(SignThrRst, MidThrRst, 65535, SpeedOneRst, SpeedTwoRst,
               SpeedThreeRst, SpeedFourRst);
    run_phase(120, 88, 0, 1'b0, 1'b0);

    load_setup($urandom_range(1000), $urandom_range(1000), $urandom_range(65535),
               $urandom_range(255), $urandom_range(255), $urandom_range(255),
               $urandom_range(255));
    run_phase(120, 0, 88, 1'b0, 1'b0);

    load_setup($urandom_range(400), $urandom_range(400), $urandom_range(300, 50),
               $urandom_range(255), $urandom_range(255), $urandom_range(255),
               $urandom_range(255));
    run_phase(120, 24, 24, 1'b0, 1'b0);

    // Low extremes: zero thresholds, zero timeout, speeds at both ends
    load_setup(0, 0, 0, 0, 255, 0, 255);
    run_phase(100, 0, 0, 1'b0, 1'b0);

    // High extremes: long quiet stretch so the gap timer saturates
    load_setup(1000, 1000, 65535, 255, 255, 255, 255);
    run_phase(320, 24, 24, 1'b1, 1'b0);

    if (fail_count == 0 && drive_pending == 0) begin
      $display("line_follow_pid_with_sign_speed: match");
    end else begin
      $display("line_follow_pid_with_sign_speed: mismatch");
    end
    $finish;
  end

endmodule
